@@ rtl/ghbp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ghbp_pkg;

    // Fixed field widths of the item and result words
    localparam int MODE_W  = 2;
    localparam int PC_W    = 32;
    localparam int PHIST_W = 4;
    localparam int COUNT_W = 32;

    // Item kinds carried in the mode field
    typedef enum logic [MODE_W-1:0] {
        MODE_PREDICT = 2'd0,
        MODE_BRANCH  = 2'd1,
        MODE_JUMP    = 2'd2
    } t_mode;

endpackage

`default_nettype wire

@@ rtl/ghbp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ghbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, register one read; read data holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/global_history_branch_predictor.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Global-history branch predictor. Each input word is a predict request, a conditional
// branch feedback or a jump-register feedback, and each gives one result word with the
// prediction, the history it used and the four statistics counts after that word.
// Saturating counters live in one synchronous RAM of 2^(HIST_BITS+INDEX_BITS) entries,
// addressed by {history, pc[INDEX_BITS+1:2]}. The RAM is read at the edge that accepts a
// word, and the counter is updated and written back as the word leaves the second stage,
// when the result word is loaded into the output register. The block takes one word per
// clock while o_in_stall is low. A write-back to the entry the following word reads is
// forwarded, and the history that a predict word uses already includes the feedback just
// ahead of it. After reset the block walks the RAM once to load every counter with
// THRESHOLD, one entry per cycle, and holds o_in_stall high until that pass is done.
module global_history_branch_predictor #(
    parameter int HIST_BITS   = 4,
    parameter int INDEX_BITS  = 10,
    parameter int COUNTER_MAX = 3,
    parameter int THRESHOLD   = 2
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [ghbp_pkg::MODE_W-1:0]   i_mode,
    input  wire logic [ghbp_pkg::PC_W-1:0]     i_pc,
    input  wire logic [ghbp_pkg::PHIST_W-1:0]  i_prediction_history,
    input  wire logic                          i_predicted_taken,
    input  wire logic                          i_actual_taken,
    input  wire logic                          i_jump_correct,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_predict_taken,
    output logic      [ghbp_pkg::PHIST_W-1:0]  o_history_used,
    output logic      [ghbp_pkg::COUNT_W-1:0]  o_correct_count,
    output logic      [ghbp_pkg::COUNT_W-1:0]  o_total_count,
    output logic      [ghbp_pkg::COUNT_W-1:0]  o_jump_correct_count,
    output logic      [ghbp_pkg::COUNT_W-1:0]  o_jump_total_count
);

    localparam int ADDR_W = HIST_BITS + INDEX_BITS;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int MAXV   = (COUNTER_MAX > THRESHOLD) ? COUNTER_MAX : THRESHOLD;
    localparam int CNT_W  = $clog2(MAXV + 1);
    localparam int CW     = ghbp_pkg::COUNT_W;
    localparam int HW     = ghbp_pkg::PHIST_W;

    localparam logic [CNT_W-1:0]  CMAX_C = CNT_W'(COUNTER_MAX);
    localparam logic [CNT_W-1:0]  THR_C  = CNT_W'(THRESHOLD);
    localparam logic [ADDR_W-1:0] LAST_A = {ADDR_W{1'b1}};

    // Clearing pass state
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    // Architectural state outside the RAM
    logic [HIST_BITS-1:0] r_hist;
    logic [CW-1:0]        r_hit;
    logic [CW-1:0]        r_br;
    logic [CW-1:0]        r_jhit;
    logic [CW-1:0]        r_jmp;

    // Second stage: word whose counter is being read
    logic                  r_s1_valid;
    ghbp_pkg::t_mode       r_s1_mode;
    logic [ADDR_W-1:0]     r_s1_addr;
    logic [HIST_BITS-1:0]  r_s1_hist;
    logic                  r_s1_pred;
    logic                  r_s1_act;
    logic                  r_s1_jc;
    logic                  r_s1_fwd;
    logic [CNT_W-1:0]      r_s1_fwd_cnt;

    // Output register
    logic          r_out_valid;
    logic          r_out_take;
    logic [HW-1:0] r_out_used;

    logic                   s1_adv;
    logic                   s1_is_br;
    logic                   s1_wr;
    logic                   in_accept;
    logic [HIST_BITS:0]     hist_shift;
    logic [HIST_BITS-1:0]   hist_eff;
    logic [HIST_BITS+HW-1:0] phist_ext;
    logic [HIST_BITS-1:0]   phist;
    logic [INDEX_BITS-1:0]  pc_idx;
    logic [ADDR_W-1:0]      rd_addr;
    logic [CNT_W-1:0]       ram_rdata;
    logic [CNT_W-1:0]       cnt_cur;
    logic [CNT_W-1:0]       cnt_new;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [CNT_W-1:0]       ram_wdata;
    logic [HIST_BITS+HW-1:0] used_ext;
    logic                   n_take;
    logic [HW-1:0]          n_used;
    logic [CW-1:0]          n_hit;
    logic [CW-1:0]          n_br;
    logic [CW-1:0]          n_jhit;
    logic [CW-1:0]          n_jmp;

    // Handshake: advance the second stage when the output register frees up
    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_clr_busy || (r_s1_valid && !s1_adv);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign s1_is_br   = (r_s1_mode == ghbp_pkg::MODE_BRANCH);
    assign s1_wr      = s1_adv && s1_is_br;

    // Form the read address with the history that the word ahead leaves behind
    assign hist_shift = {r_hist, r_s1_act};
    assign hist_eff   = (r_s1_valid && s1_is_br) ? hist_shift[HIST_BITS-1:0] : r_hist;
    assign phist_ext  = {{HIST_BITS{1'b0}}, i_prediction_history};
    assign phist      = phist_ext[HIST_BITS-1:0];
    assign pc_idx     = i_pc[INDEX_BITS+1:2];
    assign rd_addr    = (ghbp_pkg::t_mode'(i_mode) == ghbp_pkg::MODE_PREDICT)
                        ? {hist_eff, pc_idx} : {phist, pc_idx};

    // Step the counter toward the outcome with saturation
    assign cnt_cur = r_s1_fwd ? r_s1_fwd_cnt : ram_rdata;
    always_comb begin
        cnt_new = cnt_cur;
        if (r_s1_act) begin
            if (cnt_cur < CMAX_C) begin
                cnt_new = cnt_cur + CNT_W'(1);
            end
        end else begin
            if (cnt_cur != '0) begin
                cnt_new = cnt_cur - CNT_W'(1);
            end
        end
    end

    // Share the write port between the clearing pass and the write-back
    assign ram_we    = r_clr_busy || s1_wr;
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_s1_addr;
    assign ram_wdata = r_clr_busy ? THR_C : cnt_new;

    ghbp_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // Build the result word and the next counts
    assign used_ext = {{HW{1'b0}}, r_s1_hist};
    always_comb begin
        n_take = 1'b0;
        n_used = '0;
        n_hit  = r_hit;
        n_br   = r_br;
        n_jhit = r_jhit;
        n_jmp  = r_jmp;
        case (r_s1_mode)
            ghbp_pkg::MODE_PREDICT: begin
                n_take = (cnt_cur >= THR_C);
                n_used = used_ext[HW-1:0];
            end
            ghbp_pkg::MODE_BRANCH: begin
                n_br = r_br + CW'(1);
                if (r_s1_act == r_s1_pred) begin
                    n_hit = r_hit + CW'(1);
                end
            end
            ghbp_pkg::MODE_JUMP: begin
                n_jmp = r_jmp + CW'(1);
                if (r_s1_jc) begin
                    n_jhit = r_jhit + CW'(1);
                end
            end
            default: begin
                n_take = 1'b0;
            end
        endcase
    end

    // Walk the table once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == LAST_A) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Load the second stage on accept, drop it when it advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_mode    <= ghbp_pkg::t_mode'(i_mode);
            r_s1_addr    <= rd_addr;
            r_s1_hist    <= hist_eff;
            r_s1_pred    <= i_predicted_taken;
            r_s1_act     <= i_actual_taken;
            r_s1_jc      <= i_jump_correct;
            r_s1_fwd     <= s1_wr && (r_s1_addr == rd_addr);
            r_s1_fwd_cnt <= cnt_new;
        end
    end

    // Update history and statistics as a word leaves the second stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_hit  <= '0;
            r_br   <= '0;
            r_jhit <= '0;
            r_jmp  <= '0;
        end else if (s1_adv) begin
            if (s1_is_br) begin
                r_hist <= hist_shift[HIST_BITS-1:0];
            end
            r_hit  <= n_hit;
            r_br   <= n_br;
            r_jhit <= n_jhit;
            r_jmp  <= n_jmp;
        end
    end

    // Hold the result word until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_take <= n_take;
            r_out_used <= n_used;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_predict_taken      = r_out_take;
    assign o_history_used       = r_out_used;
    assign o_correct_count      = r_hit;
    assign o_total_count        = r_br;
    assign o_jump_correct_count = r_jhit;
    assign o_jump_total_count   = r_jmp;

endmodule

`default_nettype wire
